[rtl/core/adsr_pkg.sv]
// Shared types, codes and helpers for the envelope generator.
package adsr_pkg;

  localparam logic [15:0] UNITY = 16'h8000;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_WRITE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_ENV_MODE    = 3'd0,
    CFG_ATTACK      = 3'd1,
    CFG_DECAY       = 3'd2,
    CFG_SUSTAIN     = 3'd3,
    CFG_RELEASE     = 3'd4,
    CFG_STAGE_COUNT = 3'd5,
    CFG_HOLD_STAGE  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] velocity;
    logic [3:0]  stage_index;
    logic [23:0] stage_samples;
    logic [15:0] stage_level;
  } in_item_t;

  typedef struct packed {
    logic [15:0] level;
    logic        active;
  } out_item_t;

  // Clamp a level to full scale.
  function automatic logic [15:0] sat_level(input logic [16:0] v);
    sat_level = (v > 17'(UNITY)) ? UNITY : v[15:0];
  endfunction

endpackage

[rtl/core/adsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module adsr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/adsr_div.sv]
// Restoring divider: 15-bit fraction num * 2^15 / den, num < den, one bit a cycle.
module adsr_div #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [14:0]  q
);

  logic         busy;
  logic [3:0]   cnt;
  logic [W-1:0] rem;
  logic [W-1:0] den_r;
  logic [W:0]   sh;

  assign sh   = {rem, 1'b0};
  assign done = busy && (cnt == 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 4'd0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= 4'd15;
      rem   <= num;
      den_r <= den;
    end else if (busy) begin
      if (cnt == 4'd0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 4'd1;
        if (sh >= {1'b0, den_r}) begin
          rem <= W'(sh - {1'b0, den_r});
          q   <= {q[13:0], 1'b1};
        end else begin
          rem <= sh[W-1:0];
          q   <= {q[13:0], 1'b0};
        end
      end
    end
  end

endmodule

[rtl/core/adsr_multistage_envelope_core.sv]
// Envelope generator top level: ADSR and multistage table envelopes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_ready  | in_data  (tick/trigger/release/write)
//   out     | output    | out_valid/out_ready| out_data (level, active)
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Trigger, release and stage write items are handled in the idle state and
// leave the input open. A tick holds the input closed until its result is
// loaded; in ADSR mode it may wait on the fraction divider, and in multistage
// mode also on a stage RAM read for each stage passed. Reset clears all control
// state; the stage table holds undefined values until written. A finished
// result waits in the output register while the next item is taken; a tick
// result stalls only if the previous one is still untaken.
module adsr_multistage_envelope_core
  import adsr_pkg::*;
#(
  parameter int MAX_STAGES   = 16,
  parameter int COUNTER_BITS = 32,
  parameter int TIME_BITS    = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CB = COUNTER_BITS;
  localparam int TB = TIME_BITS;
  localparam int AW = $clog2(MAX_STAGES);
  localparam int CW = $clog2(MAX_STAGES + 1);
  localparam int SW = ((CW > 5) ? CW : 5) + 1;
  localparam int WW = ((CB > TB) ? CB : TB) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_ADSR, S_DIV, S_MULQ, S_MUL1, S_FIN1,
    S_MS0, S_MSRD, S_MSCHK, S_VEL, S_OUT
  } state_t;

  typedef enum logic [1:0] { PH_ATT, PH_DEC, PH_REL, PH_STG } phase_t;

  state_t state;
  phase_t ph;

  // configuration
  logic          env_mode;
  logic [TB-1:0] attack_samples, decay_samples, release_samples;
  logic [15:0]   sus_cfg;
  logic [4:0]    stage_count, hold_stage;
  logic [TB-1:0] snap_a, snap_d, snap_r;
  logic [15:0]   snap_s;

  // envelope state
  logic [CB-1:0] sample_counter, start_sample, rel_mark, seg_mark, now;
  logic          release_pending, running;
  logic [15:0]   held_velocity, level_at_trigger, level_at_release, current_level;
  logic [CW-1:0] stg_idx;
  logic [15:0]   seg_base;
  logic [15:0]   env, target;
  logic [14:0]   q;
  logic [45:0]   prod;

  logic          in_fire;
  logic [31:0]   cfg32, samp32, idx32;

  // table RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [TB+15:0]    ram_wdata, ram_rdata;
  logic [TB-1:0]     rd_t;
  logic [15:0]       rd_l;

  // divider
  logic          div_start, div_done;
  logic [TB-1:0] div_num, div_den;
  logic [14:0]   div_q;

  // shared multiplier
  logic [29:0] mul_a;
  logic [15:0] mul_b;
  logic        mul_en;

  // timing and stage compares
  logic [WW-1:0] e_w, r_w, ad_w, em_w, t_w;
  logic [SW-1:0] cnt_x, sc_x, hold_x, cs_x, cs1_x;
  logic          has_hold, up;
  logic [15:0]   diff;
  logic [16:0]   fin;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cfg32    = 32'(cfg_data);
  assign samp32   = 32'(in_data.stage_samples);
  assign idx32    = 32'(in_data.stage_index);

  assign e_w  = WW'(CB'(now - start_sample));
  assign r_w  = WW'(CB'(now - rel_mark));
  assign em_w = WW'(CB'(now - seg_mark));
  assign ad_w = WW'(snap_a) + WW'(snap_d);
  assign rd_t = ram_rdata[TB+15:16];
  assign rd_l = ram_rdata[15:0];
  assign t_w  = WW'(rd_t);

  assign sc_x     = SW'(stage_count);
  assign cnt_x    = (sc_x > SW'(MAX_STAGES)) ? SW'(MAX_STAGES) : sc_x;
  assign hold_x   = SW'(hold_stage);
  assign cs_x     = SW'(stg_idx);
  assign cs1_x    = cs_x + SW'(1);
  assign has_hold = hold_x < cnt_x;

  assign up   = target >= seg_base;
  assign diff = up ? (target - seg_base) : (seg_base - target);

  // stage writes happen only in idle, read data is used only during a tick: no overlap
  assign ram_we    = in_fire && (in_data.kind == KIND_WRITE) && (idx32 < 32'(MAX_STAGES));
  assign ram_waddr = idx32[AW-1:0];
  assign ram_wdata = {samp32[TB-1:0], sat_level({1'b0, in_data.stage_level})};

  adsr_ram #(.W(TB + 16), .D(MAX_STAGES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(stg_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  adsr_div #(.W(TB)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .q    (div_q)
  );

  // divider launch: pick the elapsed time and length for the phase
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_ADSR) begin
      if (release_pending) begin
        div_start = (r_w < WW'(snap_r));
        div_num   = r_w[TB-1:0];
        div_den   = snap_r;
      end else if (e_w < WW'(snap_a)) begin
        div_start = 1'b1;
        div_num   = e_w[TB-1:0];
        div_den   = snap_a;
      end else if (e_w < ad_w) begin
        div_start = 1'b1;
        div_num   = TB'(e_w - WW'(snap_a));
        div_den   = snap_d;
      end
    end else if (state == S_MSCHK) begin
      div_start = (em_w < t_w);
      div_num   = em_w[TB-1:0];
      div_den   = rd_t;
    end
  end

  // multiplier operands per step
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_MULQ: begin
        mul_a = 30'(q);
        mul_b = 16'(q);
      end
      S_MUL1: begin
        case (ph)
          PH_ATT: begin
            mul_a = prod[29:0];
            mul_b = UNITY - level_at_trigger;
          end
          PH_DEC: begin
            mul_a = 30'(q);
            mul_b = UNITY - snap_s;
          end
          PH_REL: begin
            mul_a = 30'(UNITY - 16'(q));
            mul_b = level_at_release;
          end
          default: begin
            mul_a = 30'(q);
            mul_b = diff;
          end
        endcase
      end
      S_VEL: begin
        mul_a = 30'(env);
        mul_b = held_velocity;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // combine the product into the envelope level
  always_comb begin
    case (ph)
      PH_ATT:  fin = 17'(level_at_trigger) + 17'(prod[45:30]);
      PH_DEC:  fin = 17'(UNITY) - 17'(prod[30:15]);
      PH_REL:  fin = 17'(prod[30:15]);
      default: fin = up ? (17'(seg_base) + 17'(prod[30:15]))
                        : (17'(seg_base) - 17'(prod[30:15]));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ph               <= PH_ATT;
      out_valid        <= 1'b0;
      env_mode         <= 1'b0;
      attack_samples   <= '0;
      decay_samples    <= '0;
      sus_cfg          <= UNITY;
      release_samples  <= '0;
      stage_count      <= 5'd0;
      hold_stage       <= 5'd16;
      snap_a           <= '0;
      snap_d           <= '0;
      snap_s           <= UNITY;
      snap_r           <= '0;
      sample_counter   <= '0;
      start_sample     <= '0;
      rel_mark         <= '0;
      release_pending  <= 1'b0;
      running          <= 1'b0;
      held_velocity    <= UNITY;
      level_at_trigger <= '0;
      level_at_release <= '0;
      current_level    <= '0;
      stg_idx          <= '0;
      seg_mark         <= '0;
      seg_base         <= '0;
    end else begin
      // load a finished result when the output register is free, drop it once taken
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (mul_en) begin
        prod <= 46'(mul_a) * 46'(mul_b);
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_ENV_MODE:    env_mode        <= cfg_data[0];
          CFG_ATTACK:      attack_samples  <= cfg32[TB-1:0];
          CFG_DECAY:       decay_samples   <= cfg32[TB-1:0];
          CFG_SUSTAIN:     sus_cfg         <= cfg_data[15:0];
          CFG_RELEASE:     release_samples <= cfg32[TB-1:0];
          CFG_STAGE_COUNT: stage_count     <= cfg_data[4:0];
          CFG_HOLD_STAGE:  hold_stage      <= cfg_data[4:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data.kind)
              KIND_TICK: begin
                now            <= sample_counter;
                sample_counter <= sample_counter + CB'(1);
                if (!running) begin
                  env   <= '0;
                  state <= S_VEL;
                end else if (env_mode) begin
                  state <= S_MS0;
                end else begin
                  state <= S_ADSR;
                end
              end
              KIND_TRIGGER: begin
                snap_a           <= attack_samples;
                snap_d           <= decay_samples;
                snap_s           <= sat_level({1'b0, sus_cfg});
                snap_r           <= release_samples;
                level_at_trigger <= running ? current_level : 16'd0;
                start_sample     <= sample_counter;
                release_pending  <= 1'b0;
                held_velocity    <= sat_level({1'b0, in_data.velocity});
                running          <= 1'b1;
                if (env_mode) begin
                  stg_idx  <= '0;
                  seg_mark <= sample_counter;
                  seg_base <= running ? current_level : 16'd0;
                end
              end
              KIND_RELEASE: begin
                if (running && !release_pending) begin
                  rel_mark         <= sample_counter;
                  level_at_release <= current_level;
                  release_pending  <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end

        S_ADSR: begin
          if (release_pending) begin
            if (r_w >= WW'(snap_r)) begin
              running       <= 1'b0;
              env           <= '0;
              current_level <= '0;
              state         <= S_VEL;
            end else begin
              ph    <= PH_REL;
              state <= S_DIV;
            end
          end else if (e_w < WW'(snap_a)) begin
            ph    <= PH_ATT;
            state <= S_DIV;
          end else if (e_w < ad_w) begin
            ph    <= PH_DEC;
            state <= S_DIV;
          end else begin
            // sustain; a zero sustain ends the envelope
            if (snap_s == 16'd0) begin
              running <= 1'b0;
            end
            env           <= snap_s;
            current_level <= snap_s;
            state         <= S_VEL;
          end
        end

        S_DIV: begin
          if (div_done) begin
            q     <= div_q;
            state <= (ph == PH_ATT) ? S_MULQ : S_MUL1;
          end
        end

        S_MULQ: state <= S_MUL1;
        S_MUL1: state <= S_FIN1;

        S_FIN1: begin
          env           <= sat_level(fin);
          current_level <= sat_level(fin);
          state         <= S_VEL;
        end

        S_MS0: begin
          if (cnt_x == '0) begin
            running <= 1'b0;
            env     <= '0;
            state   <= S_VEL;
          end else if (cs_x >= cnt_x) begin
            running       <= 1'b0;
            current_level <= '0;
            env           <= '0;
            state         <= S_VEL;
          end else if (release_pending && has_hold && (cs_x <= hold_x) && (cs1_x < cnt_x)) begin
            // jump past the held stage
            stg_idx  <= CW'(hold_x + SW'(1));
            seg_mark <= now;
            seg_base <= current_level;
            if (hold_x + SW'(1) >= cnt_x) begin
              running       <= 1'b0;
              current_level <= '0;
              env           <= '0;
              state         <= S_VEL;
            end else begin
              state <= S_MSRD;
            end
          end else begin
            state <= S_MSRD;
          end
        end

        S_MSRD: state <= S_MSCHK;

        S_MSCHK: begin
          target <= rd_l;
          if (em_w >= t_w) begin
            if (has_hold && (cs_x == hold_x) && !release_pending) begin
              current_level <= rd_l;
              env           <= rd_l;
              state         <= S_VEL;
            end else if (cs1_x >= cnt_x) begin
              stg_idx       <= CW'(cs1_x);
              running       <= 1'b0;
              current_level <= '0;
              env           <= '0;
              state         <= S_VEL;
            end else begin
              // advance to the next stage and read it
              stg_idx  <= CW'(cs1_x);
              seg_mark <= seg_mark + CB'(rd_t);
              seg_base <= rd_l;
              state    <= S_MSRD;
            end
          end else begin
            ph    <= PH_STG;
            state <= S_DIV;
          end
        end

        S_VEL: state <= S_OUT;

        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.level  <= sat_level(prod[31:15]);
            out_data.active <= running;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/adsr_chk.sv]
// Port-level checker for the envelope generator, bound to the top level.
module adsr_chk
  import adsr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed or dropped");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.level <= UNITY)
    else $error("level above full scale");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.active |-> out_data.level == 16'd0)
    else $error("inactive item with nonzero level");

  // a tick keeps the input closed while it is worked on
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.kind == KIND_TICK) |=> !in_ready)
    else $error("input open right after a tick item");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind adsr_multistage_envelope_core adsr_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
